FILE: rtl/core/crr_pkg.sv
package crr_pkg;

  // Word format and camera table layout.
  localparam int WORD_W    = 32;
  localparam int NUM_SLOTS = 15;
  localparam int EXT_W     = 66;

  localparam int SLOT_TX = 9;
  localparam int SLOT_TY = 10;
  localparam int SLOT_TZ = 11;
  localparam int SLOT_F  = 12;
  localparam int SLOT_K1 = 13;
  localparam int SLOT_K2 = 14;

  // Command and result kind codes.
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_RESID  = 1'b1;

  localparam logic signed [EXT_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [EXT_W-1:0] SAT_MIN = -66'sd2147483648;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [EXT_W-1:0] ext_t;
  typedef logic signed [2*WORD_W-1:0] prod_t;
  typedef logic [NUM_SLOTS-1:0][WORD_W-1:0] words_t;

  // Control and side data that travels with each request.
  typedef struct packed {
    logic  valid;
    logic  kind;
    logic  fault;
    logic  zero;
    word_t meas_u;
    word_t meas_v;
    word_t focal;
    word_t k1;
    word_t k2;
  } sb_t;

  typedef struct packed {
    word_t val;
    logic  ovf;
  } sat_t;

  // Clamp a wide value to the signed 32-bit range and flag the clamp.
  function automatic sat_t sat32(input ext_t x);
    sat_t r;
    if (x > SAT_MAX) begin
      r.val = 32'sh7fffffff;
      r.ovf = 1'b1;
    end else if (x < SAT_MIN) begin
      r.val = 32'sh80000000;
      r.ovf = 1'b1;
    end else begin
      r.val = x[WORD_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // Arithmetic right shift of a full product, sign extended.
  function automatic ext_t fx_shr(input prod_t p, input int unsigned sh);
    ext_t e;
    e = p;
    return e >>> sh;
  endfunction

  function automatic ext_t ext(input word_t w);
    ext_t e;
    e = w;
    return e;
  endfunction

endpackage

FILE: rtl/core/crr_cam_table.sv
module crr_cam_table #(
  parameter int CAMERA_COUNT = 256,
  parameter int AW           = 8
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [3:0]            wr_slot_i,
  input  logic [AW-1:0]         wr_cam_i,
  input  crr_pkg::word_t        wr_data_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_cam_i,
  output crr_pkg::words_t       rd_words_o
);

  // One bank per slot so that a request reads all words of a camera at once.
  for (genvar g = 0; g < crr_pkg::NUM_SLOTS; g++) begin : g_bank
    logic [crr_pkg::WORD_W-1:0] mem [CAMERA_COUNT];
    logic [crr_pkg::WORD_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_en_i && wr_slot_i == 4'(g)) begin
        mem[wr_cam_i] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_q <= mem[rd_cam_i];
      end
    end

    assign rd_words_o[g] = rd_q;
  end

endmodule

FILE: rtl/core/crr_transform.sv
module crr_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crr_pkg::words_t words_i,
  input  crr_pkg::word_t  pt_x_i,
  input  crr_pkg::word_t  pt_y_i,
  input  crr_pkg::word_t  pt_z_i,
  input  crr_pkg::sb_t    sb_i,
  output crr_pkg::word_t  cx_o,
  output crr_pkg::word_t  cy_o,
  output crr_pkg::word_t  cz_o,
  output crr_pkg::sb_t    sb_o
);

  crr_pkg::prod_t prod_q [9];
  crr_pkg::word_t t_q [3];
  crr_pkg::sb_t   sb_a_q;
  crr_pkg::word_t c_q [3];
  crr_pkg::sb_t   sb_b_q;
  crr_pkg::sb_t   sb_b_d;
  crr_pkg::word_t pt [3];
  crr_pkg::sat_t  c_sat [3];

  assign pt[0] = pt_x_i;
  assign pt[1] = pt_y_i;
  assign pt[2] = pt_z_i;

  // First stage: the nine rotation products.
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[3*r+c] <= signed'(words_i[3*r+c]) * pt[c];
      end
      t_q[r] <= signed'(words_i[crr_pkg::SLOT_TX + r]);
    end
  end

  // Second stage: row sums plus translation, clamped.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      c_sat[r] = crr_pkg::sat32(crr_pkg::fx_shr(prod_q[3*r], FRAC_BITS)
                              + crr_pkg::fx_shr(prod_q[3*r+1], FRAC_BITS)
                              + crr_pkg::fx_shr(prod_q[3*r+2], FRAC_BITS)
                              + crr_pkg::ext(t_q[r]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      c_q[r] <= c_sat[r].val;
    end
  end

  // Side data picks up the clamp events and the zero depth mark.
  always_comb begin
    sb_b_d       = sb_a_q;
    sb_b_d.fault = sb_a_q.fault | c_sat[0].ovf | c_sat[1].ovf | c_sat[2].ovf;
    sb_b_d.zero  = (c_sat[2].val == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_a_q <= '0;
      sb_b_q <= '0;
    end else begin
      sb_a_q <= sb_i;
      sb_b_q <= sb_b_d;
    end
  end

  assign cx_o = c_q[0];
  assign cy_o = c_q[1];
  assign cz_o = c_q[2];
  assign sb_o = sb_b_q;

endmodule

FILE: rtl/core/crr_divider.sv
module crr_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  crr_pkg::word_t cx_i,
  input  crr_pkg::word_t cy_i,
  input  crr_pkg::word_t cz_i,
  input  crr_pkg::sb_t   sb_i,
  output crr_pkg::word_t nx_o,
  output crr_pkg::word_t ny_o,
  output crr_pkg::sb_t   sb_o
);

  localparam int DW = crr_pkg::WORD_W + FRAC_BITS;

  // Stage 0 holds magnitudes; each later stage retires one quotient bit.
  logic [DW-1:0]               aq_q  [2][DW+1];
  logic [crr_pkg::WORD_W-1:0]  rem_q [2][DW+1];
  logic                        neg_q [2][DW+1];
  logic [crr_pkg::WORD_W-1:0]  den_q [DW+1];
  crr_pkg::sb_t                sb_q  [DW+1];
  crr_pkg::word_t              num   [2];
  crr_pkg::sat_t               q_sat [2];
  crr_pkg::word_t              n_q   [2];
  crr_pkg::sb_t                sb_out_q;
  crr_pkg::sb_t                sb_out_d;

  assign num[0] = cx_i;
  assign num[1] = cy_i;

  // Operand preparation: the quotient of -c by c.z is negative when
  // c is nonzero and has the sign of c.z.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      aq_q[l][0]  <= {(num[l][crr_pkg::WORD_W-1] ? 32'(-num[l]) : 32'(num[l])),
                      {FRAC_BITS{1'b0}}};
      rem_q[l][0] <= '0;
      neg_q[l][0] <= (num[l] != '0) &&
                     (num[l][crr_pkg::WORD_W-1] == cz_i[crr_pkg::WORD_W-1]);
    end
    den_q[0] <= cz_i[crr_pkg::WORD_W-1] ? 32'(-cz_i) : 32'(cz_i);
  end

  // Restoring steps, one register stage per quotient bit.
  for (genvar i = 0; i < DW; i++) begin : g_step
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [crr_pkg::WORD_W:0] trial;
      logic                     take;

      assign trial = {rem_q[l][i], aq_q[l][i][DW-1]};
      assign take  = (trial >= {1'b0, den_q[i]});

      always_ff @(posedge clk_i) begin
        rem_q[l][i+1] <= take ? 32'(trial - {1'b0, den_q[i]}) : trial[crr_pkg::WORD_W-1:0];
        aq_q[l][i+1]  <= {aq_q[l][i][DW-2:0], take};
        neg_q[l][i+1] <= neg_q[l][i];
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[i+1] <= den_q[i];
    end
  end

  // Apply the sign and clamp to the word range.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q_sat[l] = crr_pkg::sat32(neg_q[l][DW] ? -signed'(66'(aq_q[l][DW]))
                                             : signed'(66'(aq_q[l][DW])));
    end
  end

  always_ff @(posedge clk_i) begin
    n_q[0] <= q_sat[0].val;
    n_q[1] <= q_sat[1].val;
  end

  // A clamped quotient counts as a fault unless the depth is zero.
  always_comb begin
    sb_out_d       = sb_q[DW];
    sb_out_d.fault = sb_q[DW].fault | (!sb_q[DW].zero && (q_sat[0].ovf | q_sat[1].ovf));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DW; i++) begin
        sb_q[i] <= '0;
      end
      sb_out_q <= '0;
    end else begin
      sb_q[0] <= sb_i;
      for (int i = 0; i < DW; i++) begin
        sb_q[i+1] <= sb_q[i];
      end
      sb_out_q <= sb_out_d;
    end
  end

  assign nx_o = n_q[0];
  assign ny_o = n_q[1];
  assign sb_o = sb_out_q;

endmodule

FILE: rtl/core/crr_distort.sv
module crr_distort #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  crr_pkg::word_t nx_i,
  input  crr_pkg::word_t ny_i,
  input  crr_pkg::sb_t   sb_i,
  output crr_pkg::word_t ru_o,
  output crr_pkg::word_t rv_o,
  output crr_pkg::sb_t   sb_o
);

  localparam int NST = 11;
  localparam crr_pkg::ext_t FX_ONE = crr_pkg::ext_t'(1) <<< FRAC_BITS;

  crr_pkg::sb_t   sb_q [NST];
  crr_pkg::sb_t   sb_d [NST];
  logic           ovf  [NST];
  crr_pkg::word_t nx_q [8];
  crr_pkg::word_t ny_q [8];

  crr_pkg::prod_t pxx_q, pyy_q, pk_q, pd_q, pf_q, pu_q, pv_q;
  crr_pkg::word_t r2_q, r2b_q, r2c_q, inner_q, d_q, sc_q, ru1_q, rv1_q, ru_q, rv_q;

  crr_pkg::sat_t r2_s, inner_s, d_s, sc_s, ru1_s, rv1_s, ru_s, rv_s;

  // Clamped sums of each stage.
  always_comb begin
    r2_s    = crr_pkg::sat32(crr_pkg::fx_shr(pxx_q, FRAC_BITS) +
                             crr_pkg::fx_shr(pyy_q, FRAC_BITS));
    inner_s = crr_pkg::sat32(crr_pkg::ext(sb_q[2].k1) + crr_pkg::fx_shr(pk_q, FRAC_BITS));
    d_s     = crr_pkg::sat32(FX_ONE + crr_pkg::fx_shr(pd_q, FRAC_BITS));
    sc_s    = crr_pkg::sat32(crr_pkg::fx_shr(pf_q, FRAC_BITS));
    ru1_s   = crr_pkg::sat32(crr_pkg::fx_shr(pu_q, FRAC_BITS));
    rv1_s   = crr_pkg::sat32(crr_pkg::fx_shr(pv_q, FRAC_BITS));
    ru_s    = crr_pkg::sat32(crr_pkg::ext(ru1_q) - crr_pkg::ext(sb_q[9].meas_u));
    rv_s    = crr_pkg::sat32(crr_pkg::ext(rv1_q) - crr_pkg::ext(sb_q[9].meas_v));
  end

  // Datapath: alternating multiply and shift-add stages.
  always_ff @(posedge clk_i) begin
    nx_q[0] <= nx_i;
    ny_q[0] <= ny_i;
    for (int i = 0; i < 7; i++) begin
      nx_q[i+1] <= nx_q[i];
      ny_q[i+1] <= ny_q[i];
    end
    pxx_q   <= nx_i * nx_i;
    pyy_q   <= ny_i * ny_i;
    r2_q    <= r2_s.val;
    pk_q    <= sb_q[1].k2 * r2_q;
    r2b_q   <= r2_q;
    inner_q <= inner_s.val;
    r2c_q   <= r2b_q;
    pd_q    <= r2c_q * inner_q;
    d_q     <= d_s.val;
    pf_q    <= sb_q[5].focal * d_q;
    sc_q    <= sc_s.val;
    pu_q    <= sc_q * nx_q[7];
    pv_q    <= sc_q * ny_q[7];
    ru1_q   <= ru1_s.val;
    rv1_q   <= rv1_s.val;
    ru_q    <= ru_s.val;
    rv_q    <= rv_s.val;
  end

  // Saturation events of each stage.
  always_comb begin
    for (int i = 0; i < NST; i++) begin
      ovf[i] = 1'b0;
    end
    ovf[1]  = r2_s.ovf;
    ovf[3]  = inner_s.ovf;
    ovf[5]  = d_s.ovf;
    ovf[7]  = sc_s.ovf;
    ovf[9]  = ru1_s.ovf | rv1_s.ovf;
    ovf[10] = ru_s.ovf | rv_s.ovf;
  end

  // Side data moves one stage a cycle and collects the saturation events.
  always_comb begin
    sb_d[0] = sb_i;
    for (int i = 1; i < NST; i++) begin
      sb_d[i]       = sb_q[i-1];
      sb_d[i].fault = sb_q[i-1].fault | ovf[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        sb_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NST; i++) begin
        sb_q[i] <= sb_d[i];
      end
    end
  end

  assign ru_o = ru_q;
  assign rv_o = rv_q;
  assign sb_o = sb_q[NST-1];

endmodule

FILE: rtl/core/camera_reprojection_residual_unit.sv
// Reprojection residual engine for a pinhole camera with k1/k2 radial terms.
//
// Requests come in on a command channel: a request is taken at each rising
// edge where start_i is high and busy_o is low. busy_o stays low, so a new
// request may be issued in every cycle. A write request (command 0) stores
// one Q16.16 word of a camera; a project request (command 1) transforms a
// world point, projects and distorts it and subtracts the measured point.
// Every request gives exactly one result, in request order, shown on the
// result ports for a single cycle with valid_o high: kind_o 0 acknowledges
// a write, kind_o 1 carries resid_u_o, resid_v_o and fault_o.
// Both kinds of request take the same path through the pipeline; throughput
// is one request per cycle. The depth is set by the long division, which
// retires one quotient bit per stage in two lanes.
// The receiver cannot hold results off, so the pipeline never stalls.
// Reset clears all valid bits and the result port; the camera table is not
// cleared and a camera word must be written before any project uses it.
module camera_reprojection_residual_unit #(
  parameter int CAMERA_COUNT = 256,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [7:0]  camera_index_i,
  input  logic [3:0]  param_slot_i,
  input  logic signed [31:0] param_value_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [31:0] meas_u_i,
  input  logic signed [31:0] meas_v_i,
  output logic        valid_o,
  output logic        kind_o,
  output logic signed [31:0] resid_u_o,
  output logic signed [31:0] resid_v_o,
  output logic        fault_o
);

  localparam int AW = (CAMERA_COUNT > 1) ? $clog2(CAMERA_COUNT) : 1;

  // Input register stage.
  logic           v0_q, v1_q;
  logic           cmd0_q, cmd1_q;
  logic [7:0]     idx0_q;
  logic [3:0]     slot0_q;
  crr_pkg::word_t val0_q;
  crr_pkg::word_t px0_q, py0_q, pz0_q, mu0_q, mv0_q;
  crr_pkg::word_t px1_q, py1_q, pz1_q, mu1_q, mv1_q;
  logic [7:0]     idx_red;
  logic [AW-1:0]  cam;

  crr_pkg::words_t words;
  crr_pkg::sb_t    sb1, sb_c, sb_n, sb_r;
  crr_pkg::word_t  cx, cy, cz, nx, ny, ru, rv;

  logic           valid_q, kind_q, fault_q;
  crr_pkg::word_t resid_u_q, resid_v_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd0_q  <= command_i;
    idx0_q  <= camera_index_i;
    slot0_q <= param_slot_i;
    val0_q  <= param_value_i;
    px0_q   <= point_x_i;
    py0_q   <= point_y_i;
    pz0_q   <= point_z_i;
    mu0_q   <= meas_u_i;
    mv0_q   <= meas_v_i;
    cmd1_q  <= cmd0_q;
    px1_q   <= px0_q;
    py1_q   <= py0_q;
    pz1_q   <= pz0_q;
    mu1_q   <= mu0_q;
    mv1_q   <= mv0_q;
  end

  // Camera index modulo the table size by shifted compare and subtract.
  always_comb begin
    idx_red = idx0_q;
    for (int k = 7; k >= 0; k--) begin
      if (int'(idx_red) >= (CAMERA_COUNT << k)) begin
        idx_red = idx_red - 8'(CAMERA_COUNT << k);
      end
    end
  end

  assign cam = AW'(idx_red);

  crr_cam_table #(
    .CAMERA_COUNT(CAMERA_COUNT),
    .AW          (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (v0_q && cmd0_q == crr_pkg::CMD_WRITE),
    .wr_slot_i (slot0_q),
    .wr_cam_i  (cam),
    .wr_data_i (val0_q),
    .rd_en_i   (v0_q && cmd0_q == crr_pkg::CMD_PROJECT),
    .rd_cam_i  (cam),
    .rd_words_o(words)
  );

  // Side data joins the camera words as they leave the table.
  always_comb begin
    sb1        = '0;
    sb1.valid  = v1_q;
    sb1.kind   = (cmd1_q == crr_pkg::CMD_PROJECT) ? crr_pkg::KIND_RESID : crr_pkg::KIND_ACK;
    sb1.meas_u = mu1_q;
    sb1.meas_v = mv1_q;
    sb1.focal  = signed'(words[crr_pkg::SLOT_F]);
    sb1.k1     = signed'(words[crr_pkg::SLOT_K1]);
    sb1.k2     = signed'(words[crr_pkg::SLOT_K2]);
  end

  crr_transform #(.FRAC_BITS(FRAC_BITS)) u_transform (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .words_i(words),
    .pt_x_i (px1_q),
    .pt_y_i (py1_q),
    .pt_z_i (pz1_q),
    .sb_i   (sb1),
    .cx_o   (cx),
    .cy_o   (cy),
    .cz_o   (cz),
    .sb_o   (sb_c)
  );

  crr_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cx_i  (cx),
    .cy_i  (cy),
    .cz_i  (cz),
    .sb_i  (sb_c),
    .nx_o  (nx),
    .ny_o  (ny),
    .sb_o  (sb_n)
  );

  crr_distort #(.FRAC_BITS(FRAC_BITS)) u_distort (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .nx_i  (nx),
    .ny_i  (ny),
    .sb_i  (sb_n),
    .ru_o  (ru),
    .rv_o  (rv),
    .sb_o  (sb_r)
  );

  // Result register: acknowledges and zero-depth results carry zeros.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      kind_q    <= crr_pkg::KIND_ACK;
      fault_q   <= 1'b0;
      resid_u_q <= '0;
      resid_v_q <= '0;
    end else begin
      valid_q <= sb_r.valid;
      if (sb_r.valid && sb_r.kind == crr_pkg::KIND_RESID) begin
        kind_q    <= crr_pkg::KIND_RESID;
        fault_q   <= sb_r.fault | sb_r.zero;
        resid_u_q <= sb_r.zero ? '0 : ru;
        resid_v_q <= sb_r.zero ? '0 : rv;
      end else begin
        kind_q    <= crr_pkg::KIND_ACK;
        fault_q   <= 1'b0;
        resid_u_q <= '0;
        resid_v_q <= '0;
      end
    end
  end

  assign valid_o   = valid_q;
  assign kind_o    = kind_q;
  assign fault_o   = fault_q;
  assign resid_u_o = resid_u_q;
  assign resid_v_o = resid_v_q;

`ifndef ASSERT_OFF
  // A write acknowledge carries no residual and no fault.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o == crr_pkg::KIND_ACK |-> resid_u_o == '0 && resid_v_o == '0 && !fault_o)
    else $error("write acknowledge carries data");

  // The result port is quiet between strobes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> resid_u_o == '0 && resid_v_o == '0 && !fault_o && kind_o == crr_pkg::KIND_ACK)
    else $error("result port not quiet without strobe");

  // A transform result only follows a request that entered the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sb_c.valid |-> $past(v1_q, 2))
    else $error("transform produced a result without a request");
`endif

endmodule
